// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

    localparam int unsigned DEF_COLS     = 80;
    localparam int unsigned DEF_ROWS     = 25;
    localparam int unsigned DEF_TAB_STOP = 8;

    localparam int unsigned CELL_W    = 16;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned COLOR_W   = 8;
    localparam int unsigned ACTION_W  = 2;
    localparam int unsigned INDEX_W   = 11;
    localparam int unsigned ROW_OUT_W = 5;
    localparam int unsigned COL_OUT_W = 7;

    localparam logic [CHAR_W-1:0]  CH_TAB      = 8'd9;
    localparam logic [CHAR_W-1:0]  CH_NL       = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_CR       = 8'd13;
    localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'd32;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;
    localparam logic [CELL_W-1:0]  CELL_RESET  = {COLOR_RESET, CH_SPACE};

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef struct packed {
        logic wr;
        logic scroll;
        logic fill;
        logic rd;
    } cmd_ctl_t;

endpackage

// ===== rtl/tcw_ram.sv =====
module tcw_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tcw_fifo.sv =====
module tcw_fifo #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rptr_reg];
    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");

endmodule

// ===== rtl/tcw_front.sv =====
module tcw_front
    import tcw_pkg::*;
#(
    parameter int unsigned COLS     = DEF_COLS,
    parameter int unsigned ROWS     = DEF_ROWS,
    parameter int unsigned TAB_STOP = DEF_TAB_STOP,
    localparam int unsigned CW = $clog2(COLS),
    localparam int unsigned RW = $clog2(ROWS),
    localparam int unsigned AW = $clog2(ROWS * COLS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ACTION_W-1:0] action,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [INDEX_W-1:0]  cell_index,
    input  logic [COLOR_W-1:0]  text_color,
    input  logic                init_busy,
    input  logic                q_full,
    output logic                q_push,
    output cmd_ctl_t            cmd_ctl,
    output logic [AW-1:0]       cmd_addr,
    output logic [CELL_W-1:0]   cmd_wdata,
    output logic [RW-1:0]       cmd_row,
    output logic [CW-1:0]       cmd_col
);

    localparam int unsigned MW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int unsigned SW = $clog2(COLS + TAB_STOP);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);
    localparam logic [MW-1:0] MOD_LAST = MW'(TAB_STOP - 1);

    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [MW-1:0] mod_reg;
    logic [MW-1:0] mod_next;
    logic [SW-1:0] tab_sum;
    logic [AW-1:0] put_addr;
    logic          lf_scroll;
    logic [RW-1:0] lf_row;
    logic          accept;

    assign in_stall = q_full || init_busy;
    assign accept   = in_valid && !in_stall;
    assign q_push   = accept;

    assign tab_sum   = SW'(col_reg) + SW'(TAB_STOP) - SW'(mod_reg);
    assign put_addr  = AW'(row_reg) * AW'(COLS) + AW'(col_reg);
    assign lf_scroll = (row_reg == LAST_ROW);
    assign lf_row    = lf_scroll ? row_reg : row_reg + RW'(1);

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        mod_next  = mod_reg;
        cmd_ctl   = '0;
        cmd_addr  = put_addr;
        cmd_wdata = {text_color, char_code};
        case (action)
            ACT_PUT:
            begin
                case (char_code)
                    CH_NL:
                    begin
                        row_next       = lf_row;
                        col_next       = '0;
                        mod_next       = '0;
                        cmd_ctl.scroll = lf_scroll;
                    end
                    CH_CR:
                    begin
                        col_next = '0;
                        mod_next = '0;
                    end
                    CH_TAB:
                    begin
                        mod_next = '0;
                        if (tab_sum >= SW'(COLS))
                        begin
                            row_next       = lf_row;
                            col_next       = '0;
                            cmd_ctl.scroll = lf_scroll;
                        end
                        else
                        begin
                            col_next = CW'(tab_sum);
                        end
                    end
                    default:
                    begin
                        cmd_ctl.wr = 1'b1;
                        if (col_reg == LAST_COL)
                        begin
                            row_next       = lf_row;
                            col_next       = '0;
                            mod_next       = '0;
                            cmd_ctl.scroll = lf_scroll;
                        end
                        else
                        begin
                            col_next = col_reg + CW'(1);
                            mod_next = (mod_reg == MOD_LAST) ? '0 : mod_reg + MW'(1);
                        end
                    end
                endcase
            end
            ACT_CLEAR:
            begin
                row_next     = '0;
                col_next     = '0;
                mod_next     = '0;
                cmd_ctl.fill = 1'b1;
            end
            ACT_READ:
            begin
                cmd_addr   = AW'(cell_index);
                cmd_ctl.rd = (32'(cell_index) < 32'(ROWS * COLS));
            end
            default:
            begin
                cmd_ctl = '0;
            end
        endcase
    end

    assign cmd_row = row_next;
    assign cmd_col = col_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            mod_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            mod_reg <= mod_next;
        end
    end

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(row_reg) < 32'(ROWS)) && (32'(col_reg) < 32'(COLS)))
        else $error("cursor out of range");
    a_tab_phase: assert property (@(posedge clk) disable iff (!rst_n)
        32'(mod_reg) < 32'(TAB_STOP))
        else $error("tab phase out of range");
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> $onehot0({cmd_ctl.fill, cmd_ctl.rd, cmd_ctl.wr || cmd_ctl.scroll}))
        else $error("conflicting command flags");

endmodule

// ===== rtl/tcw_back.sv =====
module tcw_back
    import tcw_pkg::*;
#(
    parameter int unsigned COLS = DEF_COLS,
    parameter int unsigned ROWS = DEF_ROWS,
    localparam int unsigned CW = $clog2(COLS),
    localparam int unsigned RW = $clog2(ROWS),
    localparam int unsigned AW = $clog2(ROWS * COLS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [COLOR_W-1:0]   text_color,
    output logic                 init_busy,
    input  logic                 q_empty,
    output logic                 q_pop,
    input  cmd_ctl_t             cmd_ctl,
    input  logic [AW-1:0]        cmd_addr,
    input  logic [CELL_W-1:0]    cmd_wdata,
    input  logic [RW-1:0]        cmd_row,
    input  logic [CW-1:0]        cmd_col,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CELL_W-1:0]    read_data,
    output logic [ROW_OUT_W-1:0] cursor_row,
    output logic [COL_OUT_W-1:0] cursor_col
);

    localparam logic [AW-1:0] LAST_ROW_ADDR = AW'((ROWS - 1) * COLS);
    localparam logic [AW-1:0] END_ADDR      = AW'(ROWS * COLS - 1);
    localparam logic [AW-1:0] COLS_A        = AW'(COLS);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [AW-1:0]          ptr_reg;
    logic [AW-1:0]          ptr_next;
    logic                   pend_reg;
    logic                   pend_next;
    logic [AW-1:0]          wr_addr_reg;
    logic [AW-1:0]          wr_addr_next;
    logic [RW-1:0]          cur_row_reg;
    logic [RW-1:0]          cur_row_next;
    logic [CW-1:0]          cur_col_reg;
    logic [CW-1:0]          cur_col_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [CELL_W-1:0]      read_data_reg;
    logic [CELL_W-1:0]      read_data_next;
    logic [ROW_OUT_W-1:0]   cursor_row_reg;
    logic [ROW_OUT_W-1:0]   cursor_row_next;
    logic [COL_OUT_W-1:0]   cursor_col_reg;
    logic [COL_OUT_W-1:0]   cursor_col_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [CELL_W-1:0]      ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [CELL_W-1:0]      ram_rdata;
    logic                   out_free;
    logic [CELL_W-1:0]      blank;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (ROWS * COLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty && out_free;
    assign init_busy = (state_reg == ST_INIT);
    assign blank     = {text_color, CH_SPACE};

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        pend_next       = pend_reg;
        wr_addr_next    = wr_addr_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        out_valid_next  = out_valid_reg && out_stall;
        read_data_next  = read_data_reg;
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        ram_we          = 1'b0;
        ram_waddr       = ptr_reg;
        ram_wdata       = blank;
        ram_raddr       = cmd_addr;
        case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = CELL_RESET;
                if (ptr_reg == END_ADDR)
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    cur_row_next = cmd_row;
                    cur_col_next = cmd_col;
                    ram_we       = cmd_ctl.wr;
                    ram_waddr    = cmd_addr;
                    ram_wdata    = cmd_wdata;
                    ptr_next     = '0;
                    pend_next    = 1'b0;
                    if (cmd_ctl.scroll)
                    begin
                        state_next = ST_SCROLL;
                    end
                    else if (cmd_ctl.fill)
                    begin
                        state_next = ST_FILL;
                    end
                    else if (cmd_ctl.rd)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        out_valid_next  = 1'b1;
                        read_data_next  = '0;
                        cursor_row_next = ROW_OUT_W'(cmd_row);
                        cursor_col_next = COL_OUT_W'(cmd_col);
                    end
                end
            end
            ST_READ:
            begin
                out_valid_next  = 1'b1;
                read_data_next  = ram_rdata;
                cursor_row_next = ROW_OUT_W'(cur_row_reg);
                cursor_col_next = COL_OUT_W'(cur_col_reg);
                state_next      = ST_IDLE;
            end
            ST_SCROLL:
            begin
                ram_we    = pend_reg;
                ram_waddr = wr_addr_reg;
                ram_wdata = ram_rdata;
                ram_raddr = ptr_reg + COLS_A;
                if (ptr_reg == LAST_ROW_ADDR)
                begin
                    pend_next  = 1'b0;
                    state_next = ST_FILL;
                end
                else
                begin
                    pend_next    = 1'b1;
                    wr_addr_next = ptr_reg;
                    ptr_next     = ptr_reg + AW'(1);
                end
            end
            ST_FILL:
            begin
                ram_we = 1'b1;
                if (ptr_reg == END_ADDR)
                begin
                    ptr_next        = '0;
                    out_valid_next  = 1'b1;
                    read_data_next  = '0;
                    cursor_row_next = ROW_OUT_W'(cur_row_reg);
                    cursor_col_next = COL_OUT_W'(cur_col_reg);
                    state_next      = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            ptr_reg        <= '0;
            pend_reg       <= 1'b0;
            wr_addr_reg    <= '0;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            out_valid_reg  <= 1'b0;
            read_data_reg  <= '0;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            pend_reg       <= pend_next;
            wr_addr_reg    <= wr_addr_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            out_valid_reg  <= out_valid_next;
            read_data_reg  <= read_data_next;
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = read_data_reg;
    assign cursor_row = cursor_row_reg;
    assign cursor_col = cursor_col_reg;

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> out_free)
        else $error("command taken while result register is held");
    a_read_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> out_valid_reg)
        else $error("read result missing");
    a_sweep_quiet_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL || state_reg == ST_INIT) |=> !$rose(out_valid_reg))
        else $error("result raised during a sweep");
    a_scroll_to_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL && ptr_reg == LAST_ROW_ADDR) |=> state_reg == ST_FILL)
        else $error("scroll did not hand over to bottom row fill");

endmodule

// ===== rtl/text_console_writer.sv =====
// Text console engine over a ROWS x COLS store of 16-bit cells (character in
// the low byte, attribute in the high byte). After reset the block walks the
// store once, writing space on grey, and holds in_stall high meanwhile. An
// item passes the front combinationally into a two-entry command queue; the
// back owns the single-port-write cell RAM and takes a new command only from
// idle: an ordinary character, return, tab or newline off the bottom row, an
// unused action or an out-of-range read completes there, an in-range read
// goes through a read state (registered RAM read), a clear through a fill of
// every cell, and a line feed on the bottom row through a copy of rows 1 to
// ROWS-1 up by one row and a fill of the bottom row. A result waits in an
// output register while the front keeps taking items until the queue is full.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int unsigned COLS     = DEF_COLS,
    parameter int unsigned ROWS     = DEF_ROWS,
    parameter int unsigned TAB_STOP = DEF_TAB_STOP
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [COLOR_W-1:0]   cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [ACTION_W-1:0]  action,
    input  logic [CHAR_W-1:0]    char_code,
    input  logic [INDEX_W-1:0]   cell_index,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CELL_W-1:0]    read_data,
    output logic [ROW_OUT_W-1:0] cursor_row,
    output logic [COL_OUT_W-1:0] cursor_col
);

    localparam int unsigned CW = $clog2(COLS);
    localparam int unsigned RW = $clog2(ROWS);
    localparam int unsigned AW = $clog2(ROWS * COLS);
    localparam int unsigned QW = $bits(cmd_ctl_t) + AW + CELL_W + RW + CW;

    logic [COLOR_W-1:0] text_color_reg;
    logic               init_busy;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    cmd_ctl_t           f_ctl;
    logic [AW-1:0]      f_addr;
    logic [CELL_W-1:0]  f_wdata;
    logic [RW-1:0]      f_row;
    logic [CW-1:0]      f_col;
    cmd_ctl_t           b_ctl;
    logic [AW-1:0]      b_addr;
    logic [CELL_W-1:0]  b_wdata;
    logic [RW-1:0]      b_row;
    logic [CW-1:0]      b_col;
    logic [QW-1:0]      q_in;
    logic [QW-1:0]      q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= COLOR_RESET;
        end
        else if (cfg_we)
        begin
            text_color_reg <= cfg_wdata;
        end
    end

    tcw_front #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .char_code  (char_code),
        .cell_index (cell_index),
        .text_color (text_color_reg),
        .init_busy  (init_busy),
        .q_full     (q_full),
        .q_push     (q_push),
        .cmd_ctl    (f_ctl),
        .cmd_addr   (f_addr),
        .cmd_wdata  (f_wdata),
        .cmd_row    (f_row),
        .cmd_col    (f_col)
    );

    assign q_in = {f_ctl, f_addr, f_wdata, f_row, f_col};

    tcw_fifo #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign {b_ctl, b_addr, b_wdata, b_row, b_col} = q_out;

    tcw_back #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_color (text_color_reg),
        .init_busy  (init_busy),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .cmd_ctl    (b_ctl),
        .cmd_addr   (b_addr),
        .cmd_wdata  (b_wdata),
        .cmd_row    (b_row),
        .cmd_col    (b_col),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col)
    );

endmodule

// ===== test/text_console_writer_tb.sv =====
`timescale 1ns / 100ps

module text_console_writer_tb
    import tcw_pkg::*;
();

    localparam int unsigned COLS      = DEF_COLS;
    localparam int unsigned ROWS      = DEF_ROWS;
    localparam int unsigned TAB_STOP  = DEF_TAB_STOP;
    localparam int unsigned CELLS     = COLS * ROWS;
    localparam int unsigned INDEX_TOP = (1 << INDEX_W) - 1;
    localparam int          PHASES    = 6;
    localparam int          PHASE_N   = 215;
    localparam int          DIRECTED_N = 24;
    localparam int          RUN_LIMIT = 12_000_000;

    typedef struct packed {
        logic [CELL_W-1:0]    data;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
    } screen_report_t;

    typedef struct packed {
        action_t             act;
        logic [CHAR_W-1:0]   ch;
        logic [INDEX_W-1:0]  idx;
        logic                typed;
        screen_report_t      want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [COLOR_W-1:0]   cfg_wdata;
    logic                 in_valid;
    logic                 in_stall;
    logic [ACTION_W-1:0]  action;
    logic [CHAR_W-1:0]    char_code;
    logic [INDEX_W-1:0]   cell_index;
    logic                 out_valid;
    logic                 out_stall;
    logic [CELL_W-1:0]    read_data;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;

    logic [CELL_W-1:0]    screen_cells [0:CELLS-1];
    int unsigned          crow;
    int unsigned          ccol;
    logic [COLOR_W-1:0]   ink_color;

    screen_report_t       reports_due [$];
    stim_row_t            directed_rows [0:DIRECTED_N-1];
    int                   errors;
    int                   results_seen;
    int                   cycle_count;
    int                   send_calm;

    text_console_writer #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .char_code  (char_code),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col)
    );

    always #10 clk = ~clk;

    function automatic void feed_line();
        int unsigned i;
        ccol = 0;
        crow++;
        if (crow >= ROWS)
        begin
            for (i = 0; i < (ROWS - 1) * COLS; i++)
                screen_cells[i] = screen_cells[i + COLS];
            for (i = (ROWS - 1) * COLS; i < CELLS; i++)
                screen_cells[i] = {ink_color, CH_SPACE};
            crow = ROWS - 1;
        end
    endfunction

    function automatic void put_glyph(logic [CHAR_W-1:0] ch);
        if (ch == CH_NL)
            feed_line();
        else if (ch == CH_CR)
            ccol = 0;
        else if (ch == CH_TAB)
        begin
            ccol = (ccol / TAB_STOP + 1) * TAB_STOP;
            if (ccol >= COLS)
                feed_line();
        end
        else
        begin
            screen_cells[crow * COLS + ccol] = {ink_color, ch};
            ccol++;
            if (ccol >= COLS)
                feed_line();
        end
    endfunction

    function automatic screen_report_t advance_console(action_t act, logic [CHAR_W-1:0] ch,
                                                       logic [INDEX_W-1:0] idx);
        screen_report_t rep;
        int unsigned i;
        rep.data = '0;
        case (act)
            ACT_PUT:
                put_glyph(ch);
            ACT_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    screen_cells[i] = {ink_color, CH_SPACE};
                crow = 0;
                ccol = 0;
            end
            ACT_READ:
                if (idx < CELLS)
                    rep.data = screen_cells[idx];
            default:
                ;
        endcase
        rep.row = ROW_OUT_W'(crow);
        rep.col = COL_OUT_W'(ccol);
        return rep;
    endfunction

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    task automatic offer_item(input action_t act, input logic [CHAR_W-1:0] ch,
                              input logic [INDEX_W-1:0] idx, input logic typed,
                              input screen_report_t want);
        int gap;
        screen_report_t got;
        if (send_calm > 0)
            send_calm--;
        else if ($urandom_range(0, 39) == 0)
            send_calm = $urandom_range(50, 200);
        gap = (send_calm > 0) ? 0 : idle_cycles();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        char_code  <= ch;
        cell_index <= idx;
        do @(posedge clk); while (in_stall);
        got = advance_console(act, ch, idx);
        reports_due.push_back(typed ? want : got);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(negedge clk);
    endtask

    // receiver: random hold-off, calm stretches, one long hold to back up the input
    initial
    begin
        int stall_left;
        int calm;
        bit long_done;
        out_stall  = 1'b0;
        stall_left = 0;
        calm       = 0;
        long_done  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!long_done && results_seen >= 300)
            begin
                long_done  = 1'b1;
                stall_left = 600;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (calm > 0)
                    calm--;
                else if ($urandom_range(0, 49) == 0)
                    calm = $urandom_range(40, 300);
                stall_left = (calm > 0) ? 0 : idle_cycles();
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        screen_report_t head;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (reports_due.size() == 0)
            begin
                $display("%0t: unexpected beat read_data %h row %0d col %0d",
                         $time, read_data, cursor_row, cursor_col);
                errors++;
            end
            else
            begin
                head = reports_due.pop_front();
                if (read_data !== head.data)
                begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, head.data, read_data);
                    errors++;
                end
                if (cursor_row !== head.row)
                begin
                    $display("%0t: cursor_row expected %0d actual %0d",
                             $time, head.row, cursor_row);
                    errors++;
                end
                if (cursor_col !== head.col)
                begin
                    $display("%0t: cursor_col expected %0d actual %0d",
                             $time, head.col, cursor_col);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("text_console_writer verification failed");
            $finish;
        end
    end

    initial
    begin
        int p;
        int k;
        int r;
        int sub;
        action_t act;
        logic [CHAR_W-1:0] ch;
        logic [INDEX_W-1:0] idx;
        logic [COLOR_W-1:0] color;

        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        action       = ACT_NOP;
        char_code    = '0;
        cell_index   = '0;
        errors       = 0;
        results_seen = 0;
        cycle_count  = 0;
        send_calm    = 0;
        crow         = 0;
        ccol         = 0;
        ink_color    = COLOR_RESET;
        for (k = 0; k < CELLS; k++)
            screen_cells[k] = CELL_RESET;

        directed_rows = '{
            '{ACT_READ,  8'h00,  11'd0,    1'b1, '{16'h0720, 5'd0, 7'd0}},
            '{ACT_READ,  8'hFF,  11'd1999, 1'b1, '{16'h0720, 5'd0, 7'd0}},
            '{ACT_READ,  8'h00,  11'd2000, 1'b1, '{16'h0000, 5'd0, 7'd0}},
            '{ACT_READ,  8'hAA,  11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd0}},
            '{ACT_NOP,   8'hFF,  11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd0}},
            '{ACT_NOP,   8'h00,  11'd0,    1'b1, '{16'h0000, 5'd0, 7'd0}},
            '{ACT_PUT,   8'h41,  11'd0,    1'b1, '{16'h0000, 5'd0, 7'd1}},
            '{ACT_PUT,   8'h00,  11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd2}},
            '{ACT_PUT,   8'hFF,  11'h555,  1'b1, '{16'h0000, 5'd0, 7'd3}},
            '{ACT_READ,  8'h00,  11'd1,    1'b1, '{16'h0700, 5'd0, 7'd3}},
            '{ACT_READ,  8'h00,  11'd2,    1'b1, '{16'h07FF, 5'd0, 7'd3}},
            '{ACT_PUT,   CH_TAB, 11'd0,    1'b1, '{16'h0000, 5'd0, 7'd8}},
            '{ACT_PUT,   CH_TAB, 11'd0,    1'b1, '{16'h0000, 5'd0, 7'd16}},
            '{ACT_PUT,   CH_CR,  11'd0,    1'b1, '{16'h0000, 5'd0, 7'd0}},
            '{ACT_PUT,   CH_NL,  11'd0,    1'b1, '{16'h0000, 5'd1, 7'd0}},
            '{ACT_PUT,   8'h7E,  11'd0,    1'b1, '{16'h0000, 5'd1, 7'd1}},
            '{ACT_READ,  8'h00,  11'd80,   1'b1, '{16'h077E, 5'd1, 7'd1}},
            '{ACT_PUT,   8'h1B,  11'd3,    1'b0, '0},
            '{ACT_PUT,   8'h08,  11'd4,    1'b0, '0},
            '{ACT_CLEAR, 8'h41,  11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd0}},
            '{ACT_READ,  8'h00,  11'd0,    1'b1, '{16'h0720, 5'd0, 7'd0}},
            '{ACT_READ,  8'h00,  11'd80,   1'b1, '{16'h0720, 5'd0, 7'd0}},
            '{ACT_PUT,   CH_NL,  11'd0,    1'b0, '0},
            '{ACT_PUT,   CH_TAB, 11'd0,    1'b0, '0}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < DIRECTED_N; k++)
            offer_item(directed_rows[k].act, directed_rows[k].ch, directed_rows[k].idx,
                       directed_rows[k].typed, directed_rows[k].want);

        for (p = 0; p < PHASES; p++)
        begin
            wait_drained();
            color = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : COLOR_W'($urandom_range(0, 255));
            cfg_we    <= 1'b1;
            cfg_wdata <= color;
            @(negedge clk);
            cfg_we    <= 1'b0;
            ink_color = color;

            for (k = 0; k < PHASE_N; k++)
            begin
                if ($urandom_range(0, 149) == 0)
                    wait_drained();
                r   = $urandom_range(0, 999);
                act = ACT_PUT;
                ch  = CHAR_W'($urandom_range(0, 255));
                idx = INDEX_W'($urandom_range(0, INDEX_TOP));
                if (r >= 996)
                    act = ACT_CLEAR;
                else if (r >= 960)
                    act = ACT_NOP;
                else if (r >= 830)
                begin
                    act = ACT_READ;
                    sub = $urandom_range(0, 9);
                    if (sub < 5)
                        idx = INDEX_W'(crow * COLS + $urandom_range(0, COLS - 1));
                    else if (sub < 9)
                        idx = INDEX_W'($urandom_range(0, CELLS - 1));
                    else
                        idx = INDEX_W'($urandom_range(CELLS, INDEX_TOP));
                end
                else if (r < 530)
                    ch = CHAR_W'($urandom_range(33, 126));
                else if (r < 630)
                    ch = CH_SPACE;
                else if (r < 730)
                    ch = CH_NL;
                else if (r < 760)
                    ch = CH_CR;
                else if (r < 800)
                    ch = CH_TAB;
                offer_item(act, ch, idx, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("text_console_writer verification clean");
        else
            $display("text_console_writer verification failed");
        $finish;
    end

endmodule
